// ===== hw/rtl/tse_pkg.sv =====
package tse_pkg;

  // fixed-point constants, 40 fraction bits (pi and 2pi in Q8.40)
  localparam logic [47:0] PI_Q40     = 48'h0324_3F6A_8886;
  localparam logic [47:0] TWO_PI_Q40 = 48'h0648_7ED5_110B;
  localparam logic [62:0] ONE_Q40    = 63'd1 << 40;

  // largest term count the block supports
  localparam logic [10:0] MAX_TERMS  = 11'd1024;

  // argument reduction: top quotient bit of |x| / 2pi
  localparam logic [2:0]  RED_TOP_K  = 3'd4;

  // configuration register indexes
  localparam logic        REG_MAX_TERMS = 1'b0;
  localparam logic        REG_TERM_THR  = 1'b1;

  typedef enum logic [1:0] {
    OP_SIN  = 2'd0,
    OP_COS  = 2'd1,
    OP_EXP  = 2'd2,
    OP_SINH = 2'd3
  } tse_op_t;

  // controller to datapath
  typedef struct packed {
    logic        load;
    logic        red_step;
    logic [2:0]  red_k;
    logic        fold;
    logic        init;
    logic        sq_start;
    logic        f_take;
    logic        term_start;
    logic        m2_start;
    logic        upd;
    logic        out_load;
    logic [10:0] idx;
  } tse_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_trig;
    logic is_exp;
    logic busy;
    logic stop;
  } tse_sts_t;

endpackage

// ===== hw/rtl/tse_in_if.sv =====
interface tse_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [31:0] x_value;

  modport source (output valid, output opcode, output x_value, input ready);
  modport sink   (input valid, input opcode, input x_value, output ready);
endinterface

// ===== hw/rtl/tse_out_if.sv =====
interface tse_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] series_value;
  logic [10:0]        terms_used;
  logic               overflow;

  modport source (output valid, output series_value, output terms_used, output overflow,
                  input ready);
  modport sink   (input valid, input series_value, input terms_used, input overflow,
                  output ready);
endinterface

// ===== hw/rtl/tse_mul.sv =====
module tse_mul
  import tse_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  input  logic        sh63,
  output logic        busy,
  output logic [62:0] res,
  output logic        ovf
);

  logic         busy_r;
  logic [2:0]   cnt_r;
  logic         pv_r;
  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic         sh_r;
  logic [63:0]  pp_r;
  logic [1:0]   sel_r;
  logic [127:0] acc_r;
  logic [62:0]  res_r;
  logic         ovf_r;

  logic [31:0]  a_part;
  logic [31:0]  b_part;
  logic [127:0] pp_sh;
  logic [127:0] rsum;
  logic [62:0]  r_q;
  logic         big;

  // one 32x32 partial product per cycle
  always_comb begin
    a_part = cnt_r[1] ? a_r[63:32] : a_r[31:0];
    b_part = cnt_r[0] ? b_r[63:32] : b_r[31:0];
  end

  // partial product placement
  always_comb begin
    case (sel_r)
      2'd0:    pp_sh = {64'd0, pp_r};
      2'd1:    pp_sh = {32'd0, pp_r, 32'd0};
      2'd2:    pp_sh = {32'd0, pp_r, 32'd0};
      default: pp_sh = {pp_r, 64'd0};
    endcase
  end

  // round half up at the shift point, saturate above 2^63-1
  always_comb begin
    rsum = acc_r + (sh_r ? (128'd1 << 62) : (128'd1 << 39));
    r_q  = sh_r ? rsum[125:63] : rsum[102:40];
    big  = sh_r ? (|rsum[127:126]) : (|rsum[127:103]);
  end

  // sequence control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 3'd0;
      pv_r   <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 3'd0;
      pv_r   <= 1'b0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 3'd1;
      pv_r  <= (cnt_r < 3'd4);
      if (cnt_r == 3'd5) begin
        busy_r <= 1'b0;
      end
    end
  end

  // operands, product and accumulator
  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      sh_r  <= sh63;
      acc_r <= 128'd0;
    end else if (busy_r) begin
      if (cnt_r < 3'd4) begin
        pp_r  <= a_part * b_part;
        sel_r <= cnt_r[1:0];
      end
      if (pv_r) begin
        acc_r <= acc_r + pp_sh;
      end
      if (cnt_r == 3'd5) begin
        res_r <= big ? {63{1'b1}} : r_q;
        ovf_r <= big;
      end
    end
  end

  assign busy = busy_r;
  assign res  = res_r;
  assign ovf  = ovf_r;

endmodule

// ===== hw/rtl/tse_rcp.sv =====
module tse_rcp
  import tse_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [21:0] d,
  output logic        busy,
  output logic [63:0] q
);

  logic        busy_r;
  logic [3:0]  cnt_r;
  logic [63:0] num_r;
  logic [21:0] rem_r;
  logic [21:0] d_r;
  logic [63:0] q_r;

  logic [21:0] rem_c;
  logic [22:0] sh_c;
  logic [3:0]  qb_c;

  // four restoring division steps per cycle
  always_comb begin
    rem_c = rem_r;
    sh_c  = 23'd0;
    qb_c  = 4'd0;
    for (int j = 0; j < 4; j++) begin
      sh_c = {rem_c, num_r[63 - j]};
      if (sh_c >= {1'b0, d_r}) begin
        sh_c        = sh_c - {1'b0, d_r};
        qb_c[3 - j] = 1'b1;
      end
      rem_c = sh_c[21:0];
    end
  end

  // sequence control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 4'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 4'd0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 4'd1;
      if (cnt_r == 4'd15) begin
        busy_r <= 1'b0;
      end
    end
  end

  // dividend 2^63 + d/2, quotient shifts in from the right
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= {1'b1, 42'd0, d[21:1]};
      rem_r <= 22'd0;
      d_r   <= d;
      q_r   <= 64'd0;
    end else if (busy_r) begin
      num_r <= {num_r[59:0], 4'd0};
      rem_r <= rem_c;
      q_r   <= {q_r[59:0], qb_c};
    end
  end

  assign busy = busy_r;
  assign q    = q_r;

endmodule

// ===== hw/rtl/tse_dp.sv =====
module tse_dp
  import tse_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         in_opcode,
  input  logic signed [31:0] in_x_value,
  input  logic [39:0]        term_thr,
  input  tse_cmd_t           cmd,
  output tse_sts_t           sts,
  output logic signed [63:0] out_series_value,
  output logic [10:0]        out_terms_used,
  output logic               out_overflow
);

  tse_op_t            op_r;
  logic               x_neg_r;
  logic [47:0]        m_r;
  logic [62:0]        f_mag_r;
  logic               f_neg_r;
  logic [62:0]        t_mag_r;
  logic               t_neg_r;
  logic signed [63:0] sum_r;
  logic [10:0]        used_r;
  logic               ovf_r;
  logic               tovf1_r;
  logic signed [63:0] out_sum_r;
  logic [10:0]        out_used_r;
  logic               out_ovf_r;

  logic               mul_start;
  logic [63:0]        mul_a;
  logic [63:0]        mul_b;
  logic               mul_busy;
  logic [62:0]        mul_res;
  logic               mul_ovf;
  logic [21:0]        rcp_d;
  logic               rcp_busy;
  logic [63:0]        rcp_q;

  logic               is_trig;
  logic               unit_start;
  logic [47:0]        x_load;
  logic [47:0]        red_c;
  logic [47:0]        fold_m;
  logic               fold_neg;
  logic [10:0]        two_i;
  logic               step_neg;
  logic               tovf;
  logic signed [64:0] term_s;
  logic signed [64:0] sum_s;
  logic               sov;
  logic signed [63:0] x_s;

  assign is_trig = (op_r == OP_SIN) || (op_r == OP_COS);

  // argument in Q8.40, its reduction step and its fold into [-pi, pi]
  always_comb begin
    x_load   = {in_x_value, 16'd0};
    red_c    = TWO_PI_Q40 << cmd.red_k;
    fold_m   = (m_r > PI_Q40) ? (TWO_PI_Q40 - m_r) : m_r;
    fold_neg = (m_r > PI_Q40) ? ~x_neg_r : x_neg_r;
    x_s      = x_neg_r ? -$signed({16'd0, m_r}) : $signed({16'd0, m_r});
  end

  // factorial factor for term number idx
  always_comb begin
    two_i = {cmd.idx[9:0], 1'b0};
    case (op_r)
      OP_EXP:  rcp_d = {11'd0, cmd.idx};
      OP_COS:  rcp_d = {11'd0, two_i} * {11'd0, two_i - 11'd1};
      default: rcp_d = {11'd0, two_i} * {11'd0, two_i + 11'd1};
    endcase
  end

  // shared multiplier operand selection
  always_comb begin
    mul_start  = cmd.sq_start | cmd.term_start | cmd.m2_start;
    unit_start = cmd.term_start;
    if (cmd.sq_start) begin
      mul_a = {16'd0, m_r};
      mul_b = {16'd0, m_r};
    end else if (cmd.term_start) begin
      mul_a = {1'b0, t_mag_r};
      mul_b = {1'b0, f_mag_r};
    end else begin
      mul_a = {1'b0, mul_res};
      mul_b = rcp_q;
    end
  end

  // new term and its addition into the sum
  always_comb begin
    step_neg = (t_neg_r ^ f_neg_r) ^ is_trig;
    tovf     = tovf1_r | mul_ovf;
    term_s   = step_neg ? -$signed({2'b00, mul_res}) : $signed({2'b00, mul_res});
    sum_s    = {sum_r[63], sum_r} + term_s;
    sov      = sum_s[64] != sum_s[63];
  end

  tse_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .sh63  (cmd.m2_start),
    .busy  (mul_busy),
    .res   (mul_res),
    .ovf   (mul_ovf)
  );

  tse_rcp u_rcp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (unit_start),
    .d     (rcp_d),
    .busy  (rcp_busy),
    .q     (rcp_q)
  );

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= tse_op_t'(in_opcode);
      x_neg_r <= in_x_value[31];
      m_r     <= in_x_value[31] ? (48'd0 - x_load) : x_load;
    end
    if (cmd.red_step && (m_r >= red_c)) begin
      m_r <= m_r - red_c;
    end
    if (cmd.fold) begin
      m_r     <= fold_m;
      x_neg_r <= fold_neg && (fold_m != 48'd0);
    end
    if (cmd.init) begin
      used_r <= 11'd1;
      ovf_r  <= 1'b0;
      f_mag_r <= {15'd0, m_r};
      f_neg_r <= x_neg_r;
      if ((op_r == OP_COS) || (op_r == OP_EXP)) begin
        t_mag_r <= ONE_Q40;
        t_neg_r <= 1'b0;
        sum_r   <= $signed({1'b0, ONE_Q40});
      end else begin
        t_mag_r <= {15'd0, m_r};
        t_neg_r <= x_neg_r;
        sum_r   <= x_s;
      end
    end
    if (cmd.f_take) begin
      f_mag_r <= mul_res;
      f_neg_r <= 1'b0;
    end
    if (cmd.m2_start) begin
      tovf1_r <= mul_ovf;
    end
    if (cmd.upd) begin
      used_r <= used_r + 11'd1;
      if (tovf) begin
        ovf_r <= 1'b1;
        sum_r <= step_neg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else if (sov) begin
        ovf_r <= 1'b1;
        sum_r <= sum_s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
        sum_r   <= sum_s[63:0];
        t_mag_r <= mul_res;
        t_neg_r <= step_neg && (mul_res != 63'd0);
      end
    end
    if (cmd.out_load) begin
      out_sum_r  <= sum_r;
      out_used_r <= used_r;
      out_ovf_r  <= ovf_r;
    end
  end

  // status back to the controller
  always_comb begin
    sts.is_trig = is_trig;
    sts.is_exp  = (op_r == OP_EXP);
    sts.busy    = mul_busy | rcp_busy;
    sts.stop    = tovf | sov | (mul_res < {23'd0, term_thr});
  end

  assign out_series_value = out_sum_r;
  assign out_terms_used   = out_used_r;
  assign out_overflow     = out_ovf_r;

endmodule

// ===== hw/rtl/tse_ctrl.sv =====
module tse_ctrl
  import tse_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [10:0] max_terms,
  input  tse_sts_t    sts,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output tse_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_RED,
    S_FOLD,
    S_INIT,
    S_SQW,
    S_CHECK,
    S_M1,
    S_M2,
    S_DONE
  } state_t;

  state_t      state_r, state_nxt;
  logic [2:0]  k_r, k_nxt;
  logic [10:0] i_r, i_nxt;
  logic [10:0] n_r, n_nxt;
  logic        out_valid_r, out_valid_nxt;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    i_nxt         = i_r;
    n_nxt         = n_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.red_k     = k_r;
    cmd.idx       = i_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_PREP;
          if (max_terms == 11'd0) begin
            n_nxt = 11'd1;
          end else if (max_terms > MAX_TERMS) begin
            n_nxt = MAX_TERMS;
          end else begin
            n_nxt = max_terms;
          end
        end
      end
      S_PREP: begin
        if (sts.is_trig) begin
          k_nxt     = RED_TOP_K;
          state_nxt = S_RED;
        end else begin
          state_nxt = S_INIT;
        end
      end
      S_RED: begin
        cmd.red_step = 1'b1;
        if (k_r == 3'd0) begin
          state_nxt = S_FOLD;
        end else begin
          k_nxt = k_r - 3'd1;
        end
      end
      S_FOLD: begin
        cmd.fold  = 1'b1;
        state_nxt = S_INIT;
      end
      S_INIT: begin
        cmd.init = 1'b1;
        i_nxt    = 11'd1;
        if (sts.is_exp) begin
          state_nxt = S_CHECK;
        end else begin
          cmd.sq_start = 1'b1;
          state_nxt    = S_SQW;
        end
      end
      S_SQW: begin
        if (!sts.busy) begin
          cmd.f_take = 1'b1;
          state_nxt  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (i_r >= n_r) begin
          state_nxt = S_DONE;
        end else begin
          cmd.term_start = 1'b1;
          state_nxt      = S_M1;
        end
      end
      S_M1: begin
        if (!sts.busy) begin
          cmd.m2_start = 1'b1;
          state_nxt    = S_M2;
        end
      end
      S_M2: begin
        if (!sts.busy) begin
          cmd.upd   = 1'b1;
          i_nxt     = i_r + 11'd1;
          state_nxt = sts.stop ? S_DONE : S_CHECK;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= 3'd0;
      i_r         <= 11'd0;
      n_r         <= 11'd1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      i_r         <= i_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== hw/rtl/taylor_series_evaluator_top.sv =====
// sequence: setup (argument reduction, x squared, as the opcode needs), then for
// each term after the first a start, the reciprocal divider running beside the shared
// 32x32 multiply, and a second multiply; the result is then registered
// throughput: one item at a time, next item taken once the result is registered
// reset (rst_n low, synchronous): control idle, max_terms 32, term_threshold 0
module taylor_series_evaluator_top
  import tse_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [39:0] cfg_wdata,
  tse_in_if.sink      in_if,
  tse_out_if.source   out_if
);

  logic [10:0] max_terms_r;
  logic [39:0] term_thr_r;
  tse_cmd_t    cmd;
  tse_sts_t    sts;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_terms_r <= 11'd32;
      term_thr_r  <= 40'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_TERMS: max_terms_r <= cfg_wdata[10:0];
        REG_TERM_THR:  term_thr_r  <= cfg_wdata;
        default:       term_thr_r  <= term_thr_r;
      endcase
    end
  end

  tse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .max_terms (max_terms_r),
    .sts       (sts),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cmd       (cmd)
  );

  tse_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_opcode        (in_if.opcode),
    .in_x_value       (in_if.x_value),
    .term_thr         (term_thr_r),
    .cmd              (cmd),
    .sts              (sts),
    .out_series_value (out_if.series_value),
    .out_terms_used   (out_if.terms_used),
    .out_overflow     (out_if.overflow)
  );

endmodule
